// ===== hdl/mca_pkg.sv =====
// Package for the momentum carry audit accumulator.
// Types, codes and summary constants; no dependencies.
package mca_pkg;

   localparam int DEFAULT_MAX_SAMPLES = 65536;
   localparam logic [31:0] DENSITY_RESET = 32'd65536000;
   localparam int SUMMARY_WORDS = 26;

   localparam logic [2:0] ERR_OK    = 3'd0;
   localparam logic [2:0] ERR_ZERO  = 3'd1;
   localparam logic [2:0] ERR_ORDER = 3'd2;
   localparam logic [2:0] ERR_VOL   = 3'd3;
   localparam logic [2:0] ERR_OVF   = 3'd4;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   // Front-to-back queue entry: one classified sample.
   typedef struct packed {
      logic        kind;
      logic [63:0] id;
      logic [1:0]  axis;
      logic [31:0] vp;
      logic [31:0] vc;
      logic [31:0] vel;
      logic        last;
      logic [2:0]  pre_err;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  idx;
      logic [63:0] main;
      logic [63:0] energy;
      logic        mc;
      logic        pc;
      logic [2:0]  err;
      logic        last;
   } result_type;

   function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd9223372036854775807) return S64_MAX;
      if (s < -65'sd9223372036854775808) return S64_MIN;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                  logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s > 65'sd9223372036854775807) return S64_MAX;
      if (s < -65'sd9223372036854775808) return S64_MIN;
      return s[63:0];
   endfunction

endpackage

// ===== hdl/mca_front.sv =====
// Front end: accepts samples, screens ids/order/volumes, pushes to queue.
// Depends on mca_pkg.
module mca_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mca_pkg::item_type in_item,
   input  logic [31:0]       density,
   input  logic              order_upd,   // back end finished a non-last sample
   input  logic              order_kind,
   input  logic [63:0]       order_id,
   input  logic              order_clr,   // summary finished
   output logic              q_valid,
   input  logic              q_ready,
   output mca_pkg::item_type q_item
);
   import mca_pkg::*;

   // One item in flight: ordering depends on the back end's verdict.
   logic     busy_ff, busy_in;
   logic     full_ff, full_in;
   item_type q_ff, q_in;
   logic     lk_ff, lk_in;
   logic [63:0] lid_ff, lid_in;
   logic [2:0]  e;

   assign in_ready = !busy_ff;
   assign q_valid  = full_ff;
   assign q_item   = q_ff;

   always_comb begin
      if (in_item.id == 64'd0) e = ERR_ZERO;
      else if (in_item.axis == 2'd3 || (in_item.kind < lk_ff) ||
               (in_item.kind == lk_ff && in_item.id <= lid_ff)) e = ERR_ORDER;
      else if (in_item.vp == 32'd0 || in_item.vc == 32'd0 || density == 32'd0)
         e = ERR_VOL;
      else e = ERR_OK;
   end

   always_comb begin
      busy_in = busy_ff;
      full_in = full_ff;
      q_in    = q_ff;
      lk_in   = lk_ff;
      lid_in  = lid_ff;
      if (full_ff && q_ready) full_in = 1'b0;
      if (order_upd) begin
         lk_in  = order_kind;
         lid_in = order_id;
      end
      if (order_clr) begin
         lk_in  = 1'b0;
         lid_in = 64'd0;
      end
      if (order_upd || order_clr) busy_in = 1'b0;
      if (in_valid && in_ready) begin
         q_in         = in_item;
         q_in.pre_err = e;
         full_in      = 1'b1;
         busy_in      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         full_ff <= 1'b0;
         lk_ff   <= 1'b0;
         lid_ff  <= 64'd0;
      end else begin
         busy_ff <= busy_in;
         full_ff <= full_in;
         lk_ff   <= lk_in;
         lid_ff  <= lid_in;
      end
      q_ff <= q_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> q_valid)
      else $error("accepted beat not queued");
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> !in_ready)
      else $error("front accepted twice");
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !q_valid)
      else $error("queue holds item while front idle");
endmodule

// ===== hdl/mca_back.sv =====
// Back end: shared 32x32 multiplier sequencer, divider, accumulators, summary.
// Depends on mca_pkg.
module mca_back #(
   parameter int MAX_SAMPLES = mca_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  mca_pkg::item_type   q_item,
   input  logic [31:0]         density,
   output logic                order_upd,
   output logic                order_kind,
   output logic [63:0]         order_id,
   output logic                order_clr,
   output logic                out_valid,
   input  logic                out_ready,
   output mca_pkg::result_type out_res
);
   import mca_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;  // mul sequence
   localparam logic [3:0] S_CHK  = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_SOUT = 4'd5;  // sample result
   localparam logic [3:0] S_SUM  = 4'd6;  // summary words
   localparam logic [3:0] S_CLR  = 4'd7;

   logic [3:0]  st_ff, st_in;
   item_type    it_ff, it_in;
   logic [4:0]  ph_ff, ph_in;     // multiply step
   logic [6:0]  dc_ff, dc_in;     // divider step
   logic [4:0]  w_ff, w_in;

   // Operand registers
   logic [31:0] vabs;
   logic [63:0] mp_ff, mp_in, mcur_ff, mcur_in, v2_ff, v2_in;
   logic [127:0] acc_ff, acc_in;   // product accumulator
   logic [63:0] pm_ff, pm_in, cm_ff, cm_in, pe_ff, pe_in, ce_ff, ce_in;
   logic        ovf_ff, ovf_in;
   logic [2:0]  err_ff, err_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;

   // State
   logic [CW-1:0] seen_ff, seen_in;
   logic [CW-1:0] kc_ff [2], kc_in [2];
   logic [CW-1:0] cc_ff [2], cc_in [2];
   logic signed [63:0] ms_ff [6], ms_in [6];
   logic signed [63:0] ps_ff [6], ps_in [6];
   logic signed [63:0] es_ff [2], es_in [2];
   logic [63:0] mx_ff [4], mx_in [4];
   logic [2:0]  stk_ff, stk_in;

   result_type  r_ff, r_in;
   logic        ov_ff, ov_in;

   logic [31:0] ma, mb;
   logic [63:0] prod_ff;
   logic [63:0] opx, opy;
   logic [3:0]  iss, con;         // {product, hi half of y, hi half of x}
   logic [1:0]  nshift;
   logic [127:0] term;
   logic        fin;

   logic signed [63:0] spm, scm, dp, de;
   logic [31:0] dv, vmax;
   logic [63:0] adp, ade;
   logic signed [63:0] sv;
   logic [127:0] rnd;
   logic [127:0] pshift;
   logic [64:0] trial;

   // Ordering state mirror so an errored sample releases without changing it.
   logic        lk_hold_kind, lkk_in;
   logic [63:0] lk_hold_id, lki_in;

   // Partial product j of the big products: mp*|v| (2 parts), mcur*|v| (2),
   // mp*v2 (4), mcur*v2 (4).
   function automatic logic [3:0] step_map(logic [4:0] j);
      if (j < 5'd2) return {2'd0, j[1:0]};
      if (j < 5'd4) return {2'd1, 2'(j - 5'd2)};
      if (j < 5'd8) return {2'd2, 2'(j - 5'd4)};
      return {2'd3, 2'(j - 5'd8)};
   endfunction

   assign vabs = it_ff.vel[31] ? (~it_ff.vel + 32'd1) : it_ff.vel;
   assign q_ready = (st_ff == S_IDLE);
   assign out_valid = ov_ff;
   assign out_res = r_ff;

   assign iss = step_map(ph_ff - 5'd3);   // issued this cycle
   assign con = step_map(ph_ff - 5'd4);   // sitting in prod_ff

   // Shared multiplier: operands chosen by step, product registered.
   always_comb begin
      ma = 32'd0;
      mb = 32'd0;
      opx = iss[2] ? mcur_ff : mp_ff;
      opy = iss[3] ? v2_ff : {32'd0, vabs};
      case (ph_ff)
         5'd0: begin ma = density; mb = it_ff.vp; end
         5'd1: begin ma = density; mb = it_ff.vc; end
         5'd2: begin ma = vabs;    mb = vabs;     end
         default: begin
            ma = iss[0] ? opx[63:32] : opx[31:0];
            mb = iss[1] ? opy[63:32] : opy[31:0];
         end
      endcase
   end

   always_ff @(posedge clock) prod_ff <= ma * mb;

   assign dv   = (it_ff.vc > it_ff.vp) ? it_ff.vc - it_ff.vp : it_ff.vp - it_ff.vc;
   assign vmax = (it_ff.vc > it_ff.vp) ? it_ff.vc : it_ff.vp;
   assign spm = it_ff.vel[31] ? -$signed(pm_ff) : $signed(pm_ff);
   assign scm = it_ff.vel[31] ? -$signed(cm_ff) : $signed(cm_ff);
   assign dp  = scm - spm;
   assign de  = $signed(ce_ff) - $signed(pe_ff);
   assign adp = dp[63] ? -dp : dp;
   assign ade = de[63] ? -de : de;
   assign trial = {rem_ff, 1'b0} - {33'd0, vmax};

   // Summary word select
   always_comb begin
      sv = 64'sd0;
      if (w_ff < 5'd2) sv = 64'(kc_ff[w_ff[0]]);
      else if (w_ff < 5'd4) sv = 64'(cc_ff[w_ff[0]]);
      else if (w_ff < 5'd10) sv = ms_ff[3'(w_ff - 5'd4)];
      else if (w_ff < 5'd16) sv = ps_ff[3'(w_ff - 5'd10)];
      else if (w_ff < 5'd19) sv = sat_sub(ps_ff[3'(w_ff - 5'd13)], ps_ff[3'(w_ff - 5'd16)]);
      else if (w_ff < 5'd21) sv = es_ff[w_ff == 5'd20];
      else if (w_ff == 5'd21) sv = sat_sub(es_ff[1], es_ff[0]);
      else sv = mx_ff[2'(w_ff - 5'd22)];
   end

   always_comb begin
      st_in = st_ff; it_in = it_ff; ph_in = ph_ff; dc_in = dc_ff; w_in = w_ff;
      mp_in = mp_ff; mcur_in = mcur_ff; v2_in = v2_ff; acc_in = acc_ff;
      pm_in = pm_ff; cm_in = cm_ff; pe_in = pe_ff; ce_in = ce_ff;
      ovf_in = ovf_ff; err_in = err_ff; rem_in = rem_ff; quo_in = quo_ff;
      seen_in = seen_ff; kc_in = kc_ff; cc_in = cc_ff; ms_in = ms_ff;
      ps_in = ps_ff; es_in = es_ff; mx_in = mx_ff; stk_in = stk_ff;
      r_in = r_ff; ov_in = ov_ff;
      order_upd = 1'b0; order_kind = it_ff.kind; order_id = it_ff.id;
      order_clr = 1'b0;
      rnd = 128'd0; pshift = 128'd0;
      nshift = 2'd0; term = 128'd0; fin = 1'b0;

      if (ov_ff && out_ready) ov_in = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               it_in = q_item;
               ph_in = 5'd0;
               ovf_in = 1'b0;
               acc_in = 128'd0;
               err_in = q_item.pre_err;
               st_in = (q_item.pre_err != ERR_OK) ? S_ACC : S_MUL;
            end
         end
         S_MUL: begin
            // prod_ff holds the product issued at step ph-1
            if (ph_ff == 5'd1) mp_in = prod_ff;
            if (ph_ff == 5'd2) mcur_in = prod_ff;
            if (ph_ff == 5'd3) v2_in = prod_ff;
            if (ph_ff >= 5'd4) begin
               nshift = {1'b0, con[0]} + {1'b0, con[1]};
               term = {64'd0, prod_ff} << {nshift, 5'd0};
               acc_in = acc_ff + term;
               fin = con[3] ? (con[1:0] == 2'd3) : (con[1:0] == 2'd1);
               if (fin) begin
                  if (con[3]) begin
                     rnd = acc_in + (128'd1 << 32);
                     pshift = rnd >> 33;
                  end else begin
                     rnd = acc_in + (128'd1 << 15);
                     pshift = rnd >> 16;
                  end
                  if (pshift[127:63] != 65'd0) ovf_in = 1'b1;
                  case (con[3:2])
                     2'd0: pm_in = pshift[63:0];
                     2'd1: cm_in = pshift[63:0];
                     2'd2: pe_in = pshift[63:0];
                     default: ce_in = pshift[63:0];
                  endcase
                  acc_in = 128'd0;
                  if (con[3:2] == 2'd3) st_in = S_CHK;
               end
            end
            ph_in = ph_ff + 5'd1;
         end
         S_CHK: begin
            if (ovf_ff || mp_ff[63] || mcur_ff[63] || seen_ff >= CW'(MAX_SAMPLES))
               err_in = ERR_OVF;
            rem_in = {32'd0, dv};
            quo_in = 64'd0;
            dc_in = 7'd0;
            st_in = ((ovf_ff || mp_ff[63] || mcur_ff[63] ||
                      seen_ff >= CW'(MAX_SAMPLES))) ? S_ACC : S_DIV;
         end
         S_DIV: begin
            // restoring divide of dv<<32 by vmax, one bit per cycle
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], 1'b0};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            if (dc_ff == 7'd31) begin
               rem_in = {rem_ff[62:0], 1'b0};
               quo_in = {quo_ff[62:0], 1'b0};
               if (!trial[64]) begin
                  rem_in = trial[63:0];
                  quo_in = {quo_ff[62:0], 1'b1};
               end
               st_in = S_ACC;
            end
            dc_in = dc_ff + 7'd1;
         end
         S_ACC: begin
            if (!ov_ff || out_ready) begin
               r_in = '0;
               r_in.err = err_ff;
               r_in.last = !it_ff.last;
               if (err_ff == ERR_OK) begin
                  r_in.main = dp;
                  r_in.energy = de;
                  r_in.mc = (it_ff.vp != it_ff.vc);
                  r_in.pc = (dp != 64'sd0);
                  kc_in[it_ff.kind] = kc_ff[it_ff.kind] + CW'(1);
                  if (it_ff.vp != it_ff.vc) cc_in[0] = cc_ff[0] + CW'(1);
                  if (dp != 64'sd0) cc_in[1] = cc_ff[1] + CW'(1);
                  ms_in[3'(it_ff.axis)] = sat_add(ms_ff[3'(it_ff.axis)], mp_ff);
                  ms_in[3'(it_ff.axis) + 3'd3] =
                     sat_add(ms_ff[3'(it_ff.axis) + 3'd3], mcur_ff);
                  ps_in[3'(it_ff.axis)] = sat_add(ps_ff[3'(it_ff.axis)], spm);
                  ps_in[3'(it_ff.axis) + 3'd3] =
                     sat_add(ps_ff[3'(it_ff.axis) + 3'd3], scm);
                  es_in[0] = sat_add(es_ff[0], pe_ff);
                  es_in[1] = sat_add(es_ff[1], ce_ff);
                  if ({16'd0, dv, 16'd0} > mx_ff[0]) mx_in[0] = {16'd0, dv, 16'd0};
                  if (quo_ff > mx_ff[1]) mx_in[1] = quo_ff;
                  if (adp > mx_ff[2]) mx_in[2] = adp;
                  if (ade > mx_ff[3]) mx_in[3] = ade;
                  order_upd = 1'b1;
               end
               if (seen_ff < CW'(MAX_SAMPLES)) seen_in = seen_ff + CW'(1);
               if (err_ff != ERR_OK && stk_ff == ERR_OK) stk_in = err_ff;
               ov_in = 1'b1;
               w_in = 5'd0;
               st_in = it_ff.last ? S_SUM : S_IDLE;
               // after a last sample the front waits for the clear
               if (it_ff.last) order_upd = 1'b0;
            end
         end
         S_SUM: begin
            if (!ov_ff || out_ready) begin
               r_in.kind = 1'b1;
               r_in.idx = w_ff;
               r_in.main = sv;
               r_in.energy = 64'd0;
               r_in.mc = (cc_ff[0] != '0);
               r_in.pc = (cc_ff[1] != '0);
               r_in.err = stk_ff;
               r_in.last = (w_ff == 5'(SUMMARY_WORDS - 1));
               ov_in = 1'b1;
               w_in = w_ff + 5'd1;
               if (w_ff == 5'(SUMMARY_WORDS - 1)) st_in = S_CLR;
            end
         end
         S_CLR: begin
            seen_in = '0; stk_in = ERR_OK;
            for (int i = 0; i < 2; i++) begin
               kc_in[i] = '0; cc_in[i] = '0; es_in[i] = '0;
            end
            for (int i = 0; i < 6; i++) begin
               ms_in[i] = '0; ps_in[i] = '0;
            end
            for (int i = 0; i < 4; i++) mx_in[i] = '0;
            order_clr = 1'b1;
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
      // Errored non-last sample must still release the front end.
      if (st_ff == S_ACC && st_in == S_IDLE && err_ff != ERR_OK) begin
         order_upd = 1'b1;
         order_kind = lk_hold_kind;
         order_id = lk_hold_id;
      end
   end

   always_comb begin
      lkk_in = lk_hold_kind;
      lki_in = lk_hold_id;
      if (st_ff == S_ACC && st_in != S_ACC && err_ff == ERR_OK) begin
         lkk_in = it_ff.kind;
         lki_in = it_ff.id;
      end
      if (st_ff == S_CLR) begin
         lkk_in = 1'b0;
         lki_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         ov_ff <= 1'b0;
         seen_ff <= '0;
         stk_ff <= ERR_OK;
         lk_hold_kind <= 1'b0;
         lk_hold_id <= 64'd0;
         for (int i = 0; i < 2; i++) begin
            kc_ff[i] <= '0; cc_ff[i] <= '0; es_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            ms_ff[i] <= '0; ps_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) mx_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         seen_ff <= seen_in;
         stk_ff <= stk_in;
         lk_hold_kind <= lkk_in;
         lk_hold_id <= lki_in;
         kc_ff <= kc_in; cc_ff <= cc_in; es_ff <= es_in;
         ms_ff <= ms_in; ps_ff <= ps_in; mx_ff <= mx_in;
      end
      it_ff <= it_in; ph_ff <= ph_in; dc_ff <= dc_in; w_ff <= w_in;
      mp_ff <= mp_in; mcur_ff <= mcur_in; v2_ff <= v2_in; acc_ff <= acc_in;
      pm_ff <= pm_in; cm_ff <= cm_in; pe_ff <= pe_in; ce_ff <= ce_in;
      ovf_ff <= ovf_in; err_ff <= err_in; rem_ff <= rem_in; quo_ff <= quo_in;
      r_ff <= r_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> $stable(out_res))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_CLR) |=> (stk_ff == ERR_OK && seen_ff == '0))
      else $error("clear incomplete");
   assert property (@(posedge clock) disable iff (reset)
      (stk_ff != ERR_OK) |=> (stk_ff == $past(stk_ff) || $past(st_ff) == S_CLR))
      else $error("sticky error lost");
endmodule

// ===== hdl/momentum_carry_audit_accumulator_unit.sv =====
// Top level of the momentum carry audit accumulator.
// Depends on mca_pkg, mca_front, mca_back.
//
// One sample per stream beat, one sample in flight. The front end screens id, order,
// axis and volumes and queues the sample; the back end runs mass, momentum and energy
// through one shared 32x32 multiplier, then a 32-step restoring divider for the
// relative volume change, then updates the sums. The next beat is taken only once the
// current sample is done: one that overflows skips the divider, a rejected one skips
// both, and a stalled result holds the next beat back. A last sample is followed by
// 26 summary beats and a clear state that zeroes all totals before the next beat is
// taken. Results wait in an output register; sample results are never dropped while
// rsp_tready is low.
module momentum_carry_audit_accumulator_unit #(
   parameter int MAX_SAMPLES = mca_pkg::DEFAULT_MAX_SAMPLES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,   // density, Q16.16
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: stable_id[63:0], axis[65:64], previous_volume[97:66],
   //        current_volume[129:98], velocity[161:130], zero fill [167:162]
   input  logic [167:0] req_tdata,
   input  logic         req_tuser,   // dof_kind
   input  logic         req_tlast,   // last_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: word_index[4:0], value_main[68:5], value_energy[132:69],
   //        metric_changed[133], momentum_changed[134], error_code[137:135],
   //        zero fill [143:138]
   output logic [143:0] rsp_tdata,
   output logic         rsp_tuser,   // record_kind
   output logic         rsp_tlast    // last_result
);
   import mca_pkg::*;

   logic [31:0] density_ff, density_in;
   item_type    in_item, q_item;
   result_type  res;
   logic        q_valid, q_ready;
   logic        order_upd, order_kind, order_clr;
   logic [63:0] order_id;

   assign density_in = csr_we ? csr_wdata : density_ff;
   always_ff @(posedge clock) begin
      if (reset) density_ff <= DENSITY_RESET;
      else density_ff <= density_in;
   end

   always_comb begin
      in_item.kind    = req_tuser;
      in_item.id      = req_tdata[63:0];
      in_item.axis    = req_tdata[65:64];
      in_item.vp      = req_tdata[97:66];
      in_item.vc      = req_tdata[129:98];
      in_item.vel     = req_tdata[161:130];
      in_item.last    = req_tlast;
      in_item.pre_err = ERR_OK;
   end

   mca_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .density(density_ff),
      .order_upd, .order_kind, .order_id, .order_clr,
      .q_valid, .q_ready, .q_item
   );

   mca_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .density(density_ff),
      .order_upd, .order_kind, .order_id, .order_clr,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_res(res)
   );

   assign rsp_tdata = {6'd0, res.err, res.pc, res.mc, res.energy, res.main, res.idx};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last;
endmodule

// ===== test/testbench.sv =====
// Self-checking bench for momentum_carry_audit_accumulator_unit.
// Depends on mca_pkg and the unit; predicts every result beat and checks it in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mca_pkg::*;

   localparam int IDLE_LIMIT = 6000;      // cycles with no beat on any channel
   localparam int SETTLE     = 150;       // back end drain plus clear cycle

   typedef struct {
      logic        kind;
      logic [63:0] id;
      logic [1:0]  axis;
      logic [31:0] vp;
      logic [31:0] vc;
      logic [31:0] vel;
      logic        last;
   } sample_type;

   logic         clock, reset;
   logic         csr_we;
   logic [31:0]  csr_wdata;
   logic         req_tvalid, req_tready;
   logic [167:0] req_tdata;
   logic         req_tuser, req_tlast;
   logic         rsp_tvalid, rsp_tready;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser, rsp_tlast;

   momentum_carry_audit_accumulator_unit dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // model copy of register and audit state
   logic [31:0]        density_m;
   logic [31:0]        kind_cnt [2];
   logic [31:0]        chg_cnt [2];
   logic signed [63:0] mass_acc [6];
   logic signed [63:0] mom_acc [6];
   logic signed [63:0] nrg_acc [2];
   logic [63:0]        max_acc [4];
   logic               prev_kind;
   logic [63:0]        prev_id;
   int unsigned        seen_cnt;
   logic [2:0]         first_err;

   sample_type pending_samples[$];
   result_type expected_beats[$];
   int         errors = 0;
   int         idle_cycles = 0;
   bit         req_taken = 0;
   bit         quiet = 0;         // no gaps on either side
   int         rsp_hold = 0;      // long receiver hold-off, counted below
   int         rsp_gap = 0;
   int         req_gap = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] clamp_sub(logic signed [63:0] a,
                                                    logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // (a*b + half) >> sh over the full product; flags anything above 2^63-1
   function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b,
                                                  int sh, inout logic ovf);
      logic [128:0] p;
      p = a * b + (129'd1 << (sh - 1));
      p = p >> sh;
      if (p[128:63] != 0) ovf = 1'b1;
      return p[63:0];
   endfunction

   function automatic logic [63:0] mag(logic signed [63:0] x);
      return x[63] ? -x : x;
   endfunction

   function automatic void clear_audit();
      for (int i = 0; i < 2; i++) begin
         kind_cnt[i] = 0; chg_cnt[i] = 0; nrg_acc[i] = 0;
      end
      for (int i = 0; i < 6; i++) begin
         mass_acc[i] = 0; mom_acc[i] = 0;
      end
      for (int i = 0; i < 4; i++) max_acc[i] = 0;
      prev_kind = 0; prev_id = 0; seen_cnt = 0; first_err = ERR_OK;
   endfunction

   function automatic void push_beat(logic kind, logic [4:0] idx, logic [63:0] main,
                                     logic [63:0] nrg, logic mc, logic pc,
                                     logic [2:0] err, logic last);
      result_type r;
      r.kind = kind; r.idx = idx; r.main = main; r.energy = nrg;
      r.mc = mc; r.pc = pc; r.err = err; r.last = last;
      expected_beats = {expected_beats, r};
   endfunction

   // Predict the beats one accepted sample causes
   function automatic void predict_audit(sample_type s);
      logic               vneg, ovf, mc, pc;
      logic [31:0]        vabs;
      logic [2:0]         err;
      logic [63:0]        mp, mcur, v2, pm, cm, pe, ce, dv, vmax, rel;
      logic signed [63:0] spm, scm, dp, de, w;
      vneg = s.vel[31];
      vabs = vneg ? -s.vel : s.vel;
      err = ERR_OK; dp = 0; de = 0; mc = 0; pc = 0; ovf = 0;
      if (s.id == 0) err = ERR_ZERO;
      else if (s.axis == 2'd3 || s.kind < prev_kind || (s.kind == prev_kind && s.id <= prev_id))
         err = ERR_ORDER;
      else if (s.vp == 0 || s.vc == 0 || density_m == 0) err = ERR_VOL;
      else begin
         mp = {32'd0, density_m} * {32'd0, s.vp};
         mcur = {32'd0, density_m} * {32'd0, s.vc};
         v2 = {32'd0, vabs} * {32'd0, vabs};
         if (mp[63] || mcur[63]) ovf = 1;
         pm = scaled_product(mp, {32'd0, vabs}, 16, ovf);
         cm = scaled_product(mcur, {32'd0, vabs}, 16, ovf);
         pe = scaled_product(mp, v2, 33, ovf);
         ce = scaled_product(mcur, v2, 33, ovf);
         if (ovf || seen_cnt >= DEFAULT_MAX_SAMPLES) err = ERR_OVF;
         else begin
            spm = vneg ? -pm : pm;
            scm = vneg ? -cm : cm;
            dv = (s.vc > s.vp) ? s.vc - s.vp : s.vp - s.vc;
            vmax = (s.vc > s.vp) ? s.vc : s.vp;
            rel = (dv << 32) / vmax;
            dp = scm - spm;
            de = ce - pe;
            mc = s.vp != s.vc;
            pc = dp != 0;
            kind_cnt[s.kind]++;
            if (mc) chg_cnt[0]++;
            if (pc) chg_cnt[1]++;
            mass_acc[s.axis] = clamp_add(mass_acc[s.axis], mp);
            mass_acc[3 + s.axis] = clamp_add(mass_acc[3 + s.axis], mcur);
            mom_acc[s.axis] = clamp_add(mom_acc[s.axis], spm);
            mom_acc[3 + s.axis] = clamp_add(mom_acc[3 + s.axis], scm);
            nrg_acc[0] = clamp_add(nrg_acc[0], pe);
            nrg_acc[1] = clamp_add(nrg_acc[1], ce);
            if ((dv << 16) > max_acc[0]) max_acc[0] = dv << 16;
            if (rel > max_acc[1]) max_acc[1] = rel;
            if (mag(dp) > max_acc[2]) max_acc[2] = mag(dp);
            if (mag(de) > max_acc[3]) max_acc[3] = mag(de);
            prev_kind = s.kind;
            prev_id = s.id;
         end
      end
      if (seen_cnt < DEFAULT_MAX_SAMPLES) seen_cnt++;
      if (err != ERR_OK && first_err == ERR_OK) first_err = err;
      push_beat(1'b0, 5'd0, dp, de, mc, pc, err, !s.last);
      if (s.last) begin
         for (int k = 0; k < SUMMARY_WORDS; k++) begin
            if (k < 2) w = kind_cnt[k];
            else if (k < 4) w = chg_cnt[k - 2];
            else if (k < 10) w = mass_acc[k - 4];
            else if (k < 16) w = mom_acc[k - 10];
            else if (k < 19) w = clamp_sub(mom_acc[k - 13], mom_acc[k - 16]);
            else if (k < 21) w = nrg_acc[k - 19];
            else if (k == 21) w = clamp_sub(nrg_acc[1], nrg_acc[0]);
            else w = max_acc[k - 22];
            push_beat(1'b1, 5'(k), w, 64'd0, chg_cnt[0] != 0, chg_cnt[1] != 0, first_err,
                      k == SUMMARY_WORDS - 1);
         end
         clear_audit();
      end
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", field, got, want);
      errors++;
   endtask

   // Monitor: predict on input beats, check output beats, run the watchdog
   always @(posedge clock) begin
      result_type e;
      bit         moved;
      moved = 0;
      if (reset) begin
         density_m = DENSITY_RESET;
         clear_audit();
      end else begin
         if (csr_we) density_m = csr_wdata;
         if (req_tvalid && req_tready) begin
            sample_type s;
            s.id = req_tdata[63:0]; s.axis = req_tdata[65:64]; s.vp = req_tdata[97:66];
            s.vc = req_tdata[129:98]; s.vel = req_tdata[161:130];
            s.kind = req_tuser; s.last = req_tlast;
            predict_audit(s);
            req_taken = 1;
            moved = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1;
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[68:5], 64'd0);
            end else begin
               e = expected_beats.pop_front();
               if (rsp_tuser !== e.kind) report_mismatch("record_kind", rsp_tuser, e.kind);
               if (rsp_tdata[4:0] !== e.idx) report_mismatch("word_index", rsp_tdata[4:0], e.idx);
               if (rsp_tdata[68:5] !== e.main) report_mismatch("value_main", rsp_tdata[68:5], e.main);
               if (rsp_tdata[132:69] !== e.energy)
                  report_mismatch("value_energy", rsp_tdata[132:69], e.energy);
               if (rsp_tdata[133] !== e.mc) report_mismatch("metric_changed", rsp_tdata[133], e.mc);
               if (rsp_tdata[134] !== e.pc)
                  report_mismatch("momentum_changed", rsp_tdata[134], e.pc);
               if (rsp_tdata[137:135] !== e.err)
                  report_mismatch("error_code", rsp_tdata[137:135], e.err);
               if (rsp_tlast !== e.last) report_mismatch("last_result", rsp_tlast, e.last);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Driver: one beat in flight, random gaps after each outside quiet mode
   always @(negedge clock) begin
      sample_type s;
      logic       nv;
      nv = req_tvalid;
      if (req_taken) nv = 0;
      req_taken = 0;
      if (!reset && !nv) begin
         if (req_gap > 0) req_gap--;
         else if (pending_samples.size() != 0) begin
            s = pending_samples.pop_front();
            req_tdata <= {6'd0, s.vel, s.vc, s.vp, s.axis, s.id};
            req_tuser <= s.kind;
            req_tlast <= s.last;
            nv = 1;
            req_gap = quiet ? 0 : pick_gap();
         end
      end
      req_tvalid <= nv;
   end

   // Receiver: random back-pressure plus the occasional long hold-off
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (quiet) rsp_tready <= 1'b1;
      else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 30) rsp_gap = pick_gap();
      end
   end

   task automatic add_sample(logic kind, logic [63:0] id, logic [1:0] axis,
                             logic [31:0] vp, logic [31:0] vc, logic [31:0] vel, logic last);
      sample_type s;
      s.kind = kind; s.id = id; s.axis = axis; s.vp = vp; s.vc = vc; s.vel = vel;
      s.last = last;
      pending_samples = {pending_samples, s};
   endtask

   // value of random bit width, so small and full-scale magnitudes both appear
   function automatic logic [31:0] rand_width();
      int wd;
      wd = $urandom_range(1, 32);
      return (wd == 32) ? $urandom : ($urandom & ((32'd1 << wd) - 1));
   endfunction

   task automatic drain();
      while (pending_samples.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_density(logic [31:0] d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= d;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Well-formed audits: ids ascending within kind, kind 0 then 1, last on the end;
   // about one beat in six is broken on purpose.
   task automatic random_audits(int count);
      int          n, sw, made;
      logic        kind;
      logic [63:0] id;
      logic [31:0] vp, vc, vel;
      logic [1:0]  ax;
      made = 0;
      while (made < count) begin
         n = $urandom_range(1, 10);
         sw = $urandom_range(0, n);
         kind = 0;
         id = {$urandom, $urandom} >> $urandom_range(0, 63);
         if (id == 0) id = 1;
         for (int i = 0; i < n; i++) begin
            if (i == sw && kind == 0) begin
               kind = 1;
               id = {$urandom, $urandom} >> $urandom_range(1, 63);
            end
            id = id + ($urandom_range(1, 3) << $urandom_range(0, 20));
            vp = rand_width();
            vc = ($urandom_range(0, 3) == 0) ? vp : rand_width();
            vel = rand_width();
            if ($urandom_range(0, 1)) vel = -vel;
            ax = 2'($urandom_range(0, 2));
            case ($urandom_range(0, 19))
               0: add_sample(1'($urandom), 64'd0, ax, vp, vc, vel, 0);
               1: add_sample(kind, id, 2'd3, vp, vc, vel, 0);
               2: add_sample(kind, id, ax, 32'd0, vc, vel, 0);
               3: add_sample(1'($urandom), {$urandom, $urandom}, 2'($urandom), $urandom,
                             $urandom, $urandom, 0);
               default: ;
            endcase
            add_sample(kind, id, ax, vp, vc, vel, i == n - 1);
            made++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0; csr_wdata = '0;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at the reset density
      add_sample(0, 64'd1, 0, 32'h10000, 32'h20000, 32'h10000, 0);      // ok
      add_sample(0, 64'd1, 0, 32'h10000, 32'h10000, 32'h10000, 0);      // repeated id
      add_sample(0, 64'd0, 1, 32'h10000, 32'h10000, 32'h10000, 0);      // zero id
      add_sample(0, 64'd2, 3, 32'h10000, 32'h10000, 32'h10000, 0);      // bad axis
      add_sample(0, 64'd3, 1, 32'd0, 32'h10000, 32'h10000, 0);          // zero volume
      add_sample(0, 64'd4, 2, 32'h10000, 32'd0, 32'h10000, 0);
      add_sample(0, 64'd5, 0, '1, '1, 32'h8000_0000, 0);                // overflow
      add_sample(0, 64'd6, 1, 32'h30000, 32'h30000, 32'd0, 0);          // no change
      add_sample(0, 64'd7, 2, 32'd1, 32'd1, 32'h7FFF_FFFF, 0);          // top velocity
      add_sample(0, 64'd8, 1, '1, 32'd1, 32'hFFFF_0000, 0);             // extreme volumes
      add_sample(0, 64'd9, 2, 32'h1234, 32'h5678, 32'hFFFF_FFFD, 0);
      add_sample(1, 64'd5, 0, 32'h8000, 32'h4000, 32'h0001_8000, 0);   // kind step up
      add_sample(0, 64'd100, 0, 32'h8000, 32'h4000, 32'h8000, 0);      // kind step down
      add_sample(1, '1, 2, 32'h10000, 32'h20000, 32'h20000, 1);        // summary, sticky
      add_sample(1, 64'd1, 1, 32'h20000, 32'h10000, 32'hFFFE_0000, 1); // one-sample audit
      add_sample(0, 64'd2, 0, 32'd1, 32'd1, 32'd1, 0);
      add_sample(0, 64'd0, 0, 32'd1, 32'd1, 32'd1, 1);                 // last with error
      drain();

      write_density(32'd1);
      random_audits(65);
      drain();

      // receiver stalls long while the sender keeps offering
      write_density('1);
      rsp_hold = 900;
      random_audits(65);
      drain();

      write_density($urandom);
      quiet = 1;
      random_audits(55);
      drain();
      quiet = 0;

      write_density(32'h10000);
      random_audits(65);
      drain();

      if (expected_beats.size() != 0) errors++;
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
